// ===== rtl/efc_pkg.sv =====
package efc_pkg;

   // Widest floor index the design supports (up to sixteen floors).
   localparam int FLOOR_ID_W = 4;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DOOR_TICKS = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_RIDERS = 1'b1;

   localparam int CSR_DATA_W   = 8;
   localparam int TICKS_W      = 8;
   localparam int RIDERS_W     = 4;
   localparam int BEAM_W       = 4;
   localparam int SEG_W        = 8;
   localparam int SERVO_W      = 7;
   localparam int SERVO_CALC_W = 10;

   localparam logic [TICKS_W-1:0]  DOOR_TICKS_RESET = 8'd145;
   localparam logic [RIDERS_W-1:0] MAX_RIDERS_RESET = 4'd4;
   localparam logic [RIDERS_W-1:0] RIDERS_FULL      = 4'd15;

   localparam logic [SERVO_CALC_W-1:0] SERVO_BASE = 10'd25;
   localparam logic [SERVO_CALC_W-1:0] SERVO_STEP = 10'd18;

   // Beam flag bits.
   localparam int BEAM_OUTER_FIRST = 0;
   localparam int BEAM_INNER_FIRST = 1;
   localparam int BEAM_EXITING     = 2;
   localparam int BEAM_ENTERING    = 3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic start;
      logic scan;
      logic emit;
   } efc_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic depart;
      logic scan_done;
   } efc_stat_type;

   function automatic logic [SEG_W-1:0] seg_code(input logic [FLOOR_ID_W-1:0] f);
      logic [SEG_W-1:0] code;
      case (f)
         4'd0:    code = 8'hBF;
         4'd1:    code = 8'h86;
         4'd2:    code = 8'hDB;
         4'd3:    code = 8'hD7;
         4'd4:    code = 8'hE6;
         default: code = 8'h00;
      endcase
      return code;
   endfunction

endpackage

// ===== rtl/elevator_floor_controller.sv =====
// Elevator floor controller. Each accepted request is one pass of the car's
// control loop: it advances the door timer, latches the hall and car buttons,
// serves the current floor, counts riders from the two doorway beams and, when
// the door timer has run out, moves the car to its next stop. Every request
// yields exactly one response carrying the floor, display pattern, door,
// alarm, rider count, direction and servo pulse count. A pass that departs
// adds the next-stop search, which examines one floor per cycle. A pass
// writes its response only once the output register is free or being taken,
// and the block takes no new request until that pass has written it. The
// response sits in an output register, so the next request is accepted while
// an earlier response still waits to be taken. The door_ticks and max_riders
// registers are written through the csr_ port (index 0 and 1) and should only
// be changed while no pass is in flight.
module elevator_floor_controller
   import efc_pkg::*;
#(
   parameter int FLOORS = 5
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [CSR_INDEX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_wdata,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_tick,
   input  logic [FLOORS-2:0]           req_up_buttons,
   input  logic [FLOORS-2:0]           req_down_buttons,
   input  logic [FLOORS-1:0]           req_car_buttons,
   input  logic                        req_outer_blocked,
   input  logic                        req_inner_blocked,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [$clog2(FLOORS)-1:0]   rsp_floor_now,
   output logic [SEG_W-1:0]            rsp_segments,
   output logic                        rsp_door_is_open,
   output logic                        rsp_alarm,
   output logic [RIDERS_W-1:0]         rsp_riders,
   output logic                        rsp_heading_up,
   output logic                        rsp_moved,
   output logic [SERVO_W-1:0]          rsp_servo_steps
);

   // The controller sequences a pass; the datapath holds all car state.
   efc_cmd_type  cmd;
   efc_stat_type stat;

   efc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   efc_datapath #(
      .FLOORS  (FLOORS),
      .FLOOR_W ($clog2(FLOORS))
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_tick          (req_tick),
      .req_up_buttons    (req_up_buttons),
      .req_down_buttons  (req_down_buttons),
      .req_car_buttons   (req_car_buttons),
      .req_outer_blocked (req_outer_blocked),
      .req_inner_blocked (req_inner_blocked),
      .rsp_floor_now     (rsp_floor_now),
      .rsp_segments      (rsp_segments),
      .rsp_door_is_open  (rsp_door_is_open),
      .rsp_alarm         (rsp_alarm),
      .rsp_riders        (rsp_riders),
      .rsp_heading_up    (rsp_heading_up),
      .rsp_moved         (rsp_moved),
      .rsp_servo_steps   (rsp_servo_steps)
   );

endmodule

// ===== rtl/efc_ctrl.sv =====
module efc_ctrl
   import efc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  efc_stat_type stat,
   output efc_cmd_type  cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = stat.depart ? ST_SCAN : ST_EMIT;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/efc_datapath.sv =====
module efc_datapath
   import efc_pkg::*;
#(
   parameter int FLOORS  = 5,
   parameter int FLOOR_W = $clog2(FLOORS)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  efc_cmd_type            cmd,
   output efc_stat_type           stat,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_tick,
   input  logic [FLOORS-2:0]      req_up_buttons,
   input  logic [FLOORS-2:0]      req_down_buttons,
   input  logic [FLOORS-1:0]      req_car_buttons,
   input  logic                   req_outer_blocked,
   input  logic                   req_inner_blocked,
   output logic [FLOOR_W-1:0]     rsp_floor_now,
   output logic [SEG_W-1:0]       rsp_segments,
   output logic                   rsp_door_is_open,
   output logic                   rsp_alarm,
   output logic [RIDERS_W-1:0]    rsp_riders,
   output logic                   rsp_heading_up,
   output logic                   rsp_moved,
   output logic [SERVO_W-1:0]     rsp_servo_steps
);

   localparam int SCAN_W = FLOOR_W + 1;
   localparam logic [SCAN_W-1:0]  SCAN_TOP  = SCAN_W'(FLOORS - 1);
   localparam logic [FLOOR_W-1:0] FLOOR_TOP = FLOOR_W'(FLOORS - 1);

   // Configuration.
   logic [TICKS_W-1:0]  door_ticks_ff;
   logic [RIDERS_W-1:0] max_riders_ff;

   // Controller state.
   logic [FLOOR_W-1:0]  cur_ff, cur_in;
   logic                up_dir_ff, up_dir_in;
   logic                open_ff, open_in;
   logic [TICKS_W-1:0]  cnt_ff, cnt_in;
   logic                run_ff, run_in;
   logic [FLOORS-1:0]   up_pend_ff, up_pend_in;
   logic [FLOORS-1:0]   dn_pend_ff, dn_pend_in;
   logic [FLOORS-1:0]   car_pend_ff, car_pend_in;
   logic [RIDERS_W-1:0] riders_ff, riders_in;
   logic [BEAM_W-1:0]   beam_ff, beam_in;
   logic                alarm_ff, alarm_in;
   logic [SCAN_W-1:0]   scan_ff, scan_in;
   logic                moved_ff, moved_in;

   // Values produced by the front part of a pass.
   logic [TICKS_W-1:0]  p_cnt;
   logic                p_open, p_run, p_expire, p_serve, p_alarm;
   logic [FLOORS-1:0]   p_up, p_dn, p_car, here;
   logic [RIDERS_W-1:0] p_riders;
   logic [BEAM_W-1:0]   p_beam;

   // Scan step.
   logic                 s_active, s_hit;
   logic [FLOOR_W-1:0]   s_idx, s_dest;
   logic [FLOORS-1:0]    s_pend;

   logic [SERVO_CALC_W-1:0] servo_full;

   always_comb begin
      p_cnt    = cnt_ff;
      p_open   = open_ff;
      p_run    = run_ff;
      p_expire = 1'b0;
      if (req_tick && run_ff) begin
         p_cnt = cnt_ff + 1'b1;
         if (p_cnt == door_ticks_ff) begin
            p_open   = 1'b0;
            p_run    = 1'b0;
            p_expire = 1'b1;
         end
      end

      p_up  = up_pend_ff | {1'b0, req_up_buttons};
      p_dn  = dn_pend_ff | {req_down_buttons, 1'b0};
      p_car = car_pend_ff | req_car_buttons;

      here    = FLOORS'(1) << cur_ff;
      p_serve = !p_open && !p_expire && ((p_up | p_dn | p_car) & here) != '0;
      if (p_serve) begin
         p_car = p_car & ~here;
         if (up_dir_ff) begin
            p_up = p_up & ~here;
         end else begin
            p_dn = p_dn & ~here;
         end
         p_open = 1'b1;
         p_cnt  = '0;
         p_run  = 1'b1;
      end

      p_riders = riders_ff;
      p_beam   = beam_ff;
      p_alarm  = alarm_ff;
      if (p_open) begin
         if (req_outer_blocked) begin
            p_cnt = '0;
            p_run = 1'b1;
            if (p_beam[BEAM_INNER_FIRST]) begin
               p_beam[BEAM_EXITING] = 1'b1;
            end else begin
               p_beam[BEAM_OUTER_FIRST] = 1'b1;
            end
         end else if (p_beam[BEAM_EXITING]) begin
            if (p_riders != '0) begin
               p_riders = p_riders - 1'b1;
            end
            p_beam[BEAM_EXITING]     = 1'b0;
            p_beam[BEAM_INNER_FIRST] = 1'b0;
         end
         if (req_inner_blocked) begin
            if (p_beam[BEAM_OUTER_FIRST]) begin
               p_beam[BEAM_ENTERING] = 1'b1;
            end else begin
               p_beam[BEAM_INNER_FIRST] = 1'b1;
            end
         end else if (p_beam[BEAM_ENTERING]) begin
            if (p_riders != RIDERS_FULL) begin
               p_riders = p_riders + 1'b1;
            end
            p_beam[BEAM_ENTERING]    = 1'b0;
            p_beam[BEAM_OUTER_FIRST] = 1'b0;
         end
         p_alarm = p_riders > max_riders_ff;
         if (p_alarm) begin
            p_cnt = '0;
            p_run = 1'b1;
         end
      end
   end

   // One floor of the next-stop search per cycle.
   always_comb begin
      s_active = (scan_ff != '0) && (scan_ff < SCAN_TOP);
      s_idx    = scan_ff[FLOOR_W-1:0];
      s_pend   = car_pend_ff | (up_dir_ff ? up_pend_ff : dn_pend_ff);
      s_hit    = s_active && s_pend[s_idx];
      if (s_hit) begin
         s_dest = s_idx;
      end else begin
         s_dest = up_dir_ff ? FLOOR_TOP : '0;
      end
   end

   assign stat.depart    = p_expire;
   assign stat.scan_done = !s_active || s_hit;

   always_comb begin
      cur_in      = cur_ff;
      up_dir_in   = up_dir_ff;
      open_in     = open_ff;
      cnt_in      = cnt_ff;
      run_in      = run_ff;
      up_pend_in  = up_pend_ff;
      dn_pend_in  = dn_pend_ff;
      car_pend_in = car_pend_ff;
      riders_in   = riders_ff;
      beam_in     = beam_ff;
      alarm_in    = alarm_ff;
      scan_in     = scan_ff;
      moved_in    = moved_ff;
      if (cmd.start) begin
         open_in     = p_open;
         cnt_in      = p_cnt;
         run_in      = p_run;
         up_pend_in  = p_up;
         dn_pend_in  = p_dn;
         car_pend_in = p_car;
         riders_in   = p_riders;
         beam_in     = p_beam;
         alarm_in    = p_alarm;
         moved_in    = 1'b0;
         if (up_dir_ff) begin
            scan_in = SCAN_W'(cur_ff) + 1'b1;
         end else begin
            scan_in = SCAN_W'(cur_ff) - 1'b1;
         end
      end else if (cmd.scan) begin
         if (stat.scan_done) begin
            cur_in   = s_dest;
            moved_in = 1'b1;
            if (s_dest == FLOOR_TOP) begin
               up_dir_in = 1'b0;
            end else if (s_dest == '0) begin
               up_dir_in = 1'b1;
            end
         end else begin
            // A floor passed without a request forces a stop at the end floor.
            if (up_dir_ff) begin
               car_pend_in = car_pend_ff | (FLOORS'(1) << FLOOR_TOP);
               scan_in     = scan_ff + 1'b1;
            end else begin
               car_pend_in = car_pend_ff | FLOORS'(1);
               scan_in     = scan_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         door_ticks_ff <= DOOR_TICKS_RESET;
         max_riders_ff <= MAX_RIDERS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DOOR_TICKS: door_ticks_ff <= csr_wdata[TICKS_W-1:0];
            CSR_MAX_RIDERS: max_riders_ff <= csr_wdata[RIDERS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff      <= '0;
         up_dir_ff   <= 1'b1;
         open_ff     <= 1'b0;
         cnt_ff      <= '0;
         run_ff      <= 1'b0;
         up_pend_ff  <= '0;
         dn_pend_ff  <= '0;
         car_pend_ff <= '0;
         riders_ff   <= '0;
         beam_ff     <= '0;
         alarm_ff    <= 1'b0;
         scan_ff     <= '0;
         moved_ff    <= 1'b0;
      end else begin
         cur_ff      <= cur_in;
         up_dir_ff   <= up_dir_in;
         open_ff     <= open_in;
         cnt_ff      <= cnt_in;
         run_ff      <= run_in;
         up_pend_ff  <= up_pend_in;
         dn_pend_ff  <= dn_pend_in;
         car_pend_ff <= car_pend_in;
         riders_ff   <= riders_in;
         beam_ff     <= beam_in;
         alarm_ff    <= alarm_in;
         scan_ff     <= scan_in;
         moved_ff    <= moved_in;
      end
   end

   assign servo_full = SERVO_BASE + SERVO_STEP * SERVO_CALC_W'(cur_ff);

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_floor_now    <= cur_ff;
         rsp_segments     <= seg_code(FLOOR_ID_W'(cur_ff));
         rsp_door_is_open <= open_ff;
         rsp_alarm        <= alarm_ff;
         rsp_riders       <= riders_ff;
         rsp_heading_up   <= up_dir_ff;
         rsp_moved        <= moved_ff;
         rsp_servo_steps  <= moved_ff ? servo_full[SERVO_W-1:0] : '0;
      end
   end

endmodule

// ===== rtl/efc_checker.sv =====
module efc_checker
   import efc_pkg::*;
#(
   parameter int FLOORS = 5
) (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [$clog2(FLOORS)-1:0] rsp_floor_now,
   input logic                      rsp_door_is_open,
   input logic                      rsp_heading_up,
   input logic                      rsp_moved,
   input logic [SERVO_W-1:0]        rsp_servo_steps
);

   // A stalled response keeps its floor and movement report.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_floor_now) && $stable(rsp_moved))
      else $error("stalled response changed");

   // The servo only gets pulses on a pass that moved the car.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_moved |-> rsp_servo_steps == '0)
      else $error("servo pulses without movement");

   // A departing car always has its door closed.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_moved |-> !rsp_door_is_open)
      else $error("car moved with door open");

   // Arriving at the bottom floor turns the car upward.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_moved && rsp_floor_now == '0 |-> rsp_heading_up)
      else $error("direction not reversed at bottom floor");

   // The car never reports a floor that does not exist.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_floor_now) < FLOORS)
      else $error("floor out of range");

endmodule

bind elevator_floor_controller efc_checker #(.FLOORS(FLOORS)) u_efc_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_floor_now    (rsp_floor_now),
   .rsp_door_is_open (rsp_door_is_open),
   .rsp_heading_up   (rsp_heading_up),
   .rsp_moved        (rsp_moved),
   .rsp_servo_steps  (rsp_servo_steps)
);

// ===== test/tb_elevator_floor_controller.sv =====
`timescale 1ns / 1ps

module tb_elevator_floor_controller;
   import efc_pkg::*;

   localparam int FLOORS = 5;
   localparam int TOP = FLOORS - 1;
   localparam int FLOOR_W = $clog2(FLOORS);

   // If nothing is accepted on either channel for this many cycles, the run is stuck.
   localparam int WATCHDOG_LIMIT = 1000;

   // Display patterns, floor 0 in the low byte.
   localparam logic [FLOORS*SEG_W-1:0] FLOOR_GLYPHS = {8'hE6, 8'hD7, 8'hDB, 8'h86, 8'hBF};

   // Doorway beam states as {outer, inner}.
   localparam logic [1:0] BEAMS_CLEAR = 2'b00;
   localparam logic [1:0] INNER_ONLY  = 2'b01;
   localparam logic [1:0] OUTER_ONLY  = 2'b10;
   localparam logic [1:0] BOTH_BEAMS  = 2'b11;

   typedef enum logic [1:0] {
      RSP_ALWAYS,
      RSP_PATTERN,
      RSP_SPARSE
   } rsp_mode_type;

   // One control loop pass, as carried by one request.
   typedef struct packed {
      logic              tick;
      logic [FLOORS-2:0] up_buttons;
      logic [FLOORS-2:0] down_buttons;
      logic [FLOORS-1:0] car_buttons;
      logic              outer;
      logic              inner;
   } loop_pass_type;

   // What the car reports after one pass.
   typedef struct packed {
      logic [FLOOR_W-1:0]  floor_now;
      logic [SEG_W-1:0]    segments;
      logic                door_is_open;
      logic                alarm;
      logic [RIDERS_W-1:0] riders;
      logic                heading_up;
      logic                moved;
      logic [SERVO_W-1:0]  servo_steps;
   } car_report_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]    csr_wdata = '0;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic                     req_tick = 1'b0;
   logic [FLOORS-2:0]        req_up_buttons = '0;
   logic [FLOORS-2:0]        req_down_buttons = '0;
   logic [FLOORS-1:0]        req_car_buttons = '0;
   logic                     req_outer_blocked = 1'b0;
   logic                     req_inner_blocked = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [FLOOR_W-1:0]       rsp_floor_now;
   logic [SEG_W-1:0]         rsp_segments;
   logic                     rsp_door_is_open;
   logic                     rsp_alarm;
   logic [RIDERS_W-1:0]      rsp_riders;
   logic                     rsp_heading_up;
   logic                     rsp_moved;
   logic [SERVO_W-1:0]       rsp_servo_steps;

   elevator_floor_controller #(
      .FLOORS(FLOORS)
   ) uut (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_tick          (req_tick),
      .req_up_buttons    (req_up_buttons),
      .req_down_buttons  (req_down_buttons),
      .req_car_buttons   (req_car_buttons),
      .req_outer_blocked (req_outer_blocked),
      .req_inner_blocked (req_inner_blocked),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_floor_now     (rsp_floor_now),
      .rsp_segments      (rsp_segments),
      .rsp_door_is_open  (rsp_door_is_open),
      .rsp_alarm         (rsp_alarm),
      .rsp_riders        (rsp_riders),
      .rsp_heading_up    (rsp_heading_up),
      .rsp_moved         (rsp_moved),
      .rsp_servo_steps   (rsp_servo_steps)
   );

   // The testbench's own copy of the car: configuration first, then state.
   logic [TICKS_W-1:0]  door_ticks_cfg;
   logic [RIDERS_W-1:0] max_riders_cfg;
   logic [FLOOR_W-1:0]  car_floor;
   logic                going_up;
   logic                door_open;
   logic                depart_due;
   logic [TICKS_W-1:0]  door_timer;
   logic                timer_running;
   logic [FLOORS-1:0]   hall_up;
   logic [FLOORS-1:0]   hall_down;
   logic [FLOORS-1:0]   car_calls;
   logic [RIDERS_W-1:0] riders;
   logic [BEAM_W-1:0]   beams;
   logic                overload;

   // Reports that the car owes, oldest first.
   car_report_type pending_reports[$];

   int        mismatch_count = 0;
   int        idle_cycles = 0;
   int        burst_left = 0;
   bit        sender_bursty = 1'b1;
   rsp_mode_type rsp_mode = RSP_PATTERN;
   logic [15:0] stall_pattern = '1;
   int        stall_age = 0;
   logic [1:0] beam_script[$];

   initial begin
      forever #1 clock = ~clock;
   end

   // Opening the door always restarts the timer from zero.
   function automatic void reopen_door();
      door_open = 1'b1;
      door_timer = '0;
      timer_running = 1'b1;
   endfunction

   // Advances the car by one pass and returns what the block should report for it.
   // The order inside a pass matters: timer, button latching, serving the current
   // floor, rider counting, and only then the departure that the timer may have armed.
   function automatic car_report_type step_car(input loop_pass_type p);
      car_report_type    rpt;
      logic [FLOORS-1:0] here;
      logic [9:0]        servo_calc;
      int                dest;
      bit                found;
      rpt = '0;

      // A tick only counts while the door timer is running.
      if (p.tick && timer_running) begin
         door_timer = door_timer + 1'b1;
         if (door_timer == door_ticks_cfg) begin
            door_open = 1'b0;
            depart_due = 1'b1;
            timer_running = 1'b0;
         end
      end

      // Down button bit k belongs to floor k+1, so the down calls shift up by one.
      hall_up = hall_up | {1'b0, p.up_buttons};
      hall_down = hall_down | {p.down_buttons, 1'b0};
      car_calls = car_calls | p.car_buttons;

      // Serve the floor the car stands at. Only the hall call in the travel
      // direction is cleared; a call the other way stays latched.
      here = '0;
      here[car_floor] = 1'b1;
      if (!door_open && !depart_due && ((hall_up | hall_down | car_calls) & here) != '0) begin
         car_calls = car_calls & ~here;
         if (going_up) hall_up = hall_up & ~here;
         else hall_down = hall_down & ~here;
         reopen_door();
      end

      // Riders are counted by which beam broke first. An outer beam holds the
      // door, and so does an overload, on every pass.
      if (door_open) begin
         if (p.outer) begin
            reopen_door();
            if (beams[BEAM_INNER_FIRST]) beams[BEAM_EXITING] = 1'b1;
            else beams[BEAM_OUTER_FIRST] = 1'b1;
         end else if (beams[BEAM_EXITING]) begin
            if (riders != '0) riders = riders - 1'b1;
            beams[BEAM_INNER_FIRST] = 1'b0;
            beams[BEAM_EXITING] = 1'b0;
         end
         if (p.inner) begin
            if (beams[BEAM_OUTER_FIRST]) beams[BEAM_ENTERING] = 1'b1;
            else beams[BEAM_INNER_FIRST] = 1'b1;
         end else if (beams[BEAM_ENTERING]) begin
            if (riders != RIDERS_FULL) riders = riders + 1'b1;
            beams[BEAM_OUTER_FIRST] = 1'b0;
            beams[BEAM_ENTERING] = 1'b0;
         end
         if (riders > max_riders_cfg) begin
            overload = 1'b1;
            reopen_door();
         end else begin
            overload = 1'b0;
         end
      end

      // Departure: scan toward the end floor in the travel direction. Every floor
      // passed without a call plants a car call at that end floor.
      if (depart_due) begin
         found = 1'b0;
         if (going_up) begin
            dest = TOP;
            for (int i = int'(car_floor) + 1; i < TOP; i++) begin
               if (!found) begin
                  if (car_calls[i] || hall_up[i]) begin
                     dest = i;
                     found = 1'b1;
                  end else begin
                     car_calls[TOP] = 1'b1;
                  end
               end
            end
         end else begin
            dest = 0;
            for (int i = int'(car_floor) - 1; i > 0; i--) begin
               if (!found) begin
                  if (car_calls[i] || hall_down[i]) begin
                     dest = i;
                     found = 1'b1;
                  end else begin
                     car_calls[0] = 1'b1;
                  end
               end
            end
         end
         servo_calc = SERVO_BASE + SERVO_STEP * 10'(dest);
         rpt.moved = 1'b1;
         rpt.servo_steps = servo_calc[SERVO_W-1:0];
         depart_due = 1'b0;
         car_floor = FLOOR_W'(dest);
         if (dest == TOP) going_up = 1'b0;
         else if (dest == 0) going_up = 1'b1;
      end

      rpt.floor_now = car_floor;
      rpt.segments = FLOOR_GLYPHS[car_floor*SEG_W +: SEG_W];
      rpt.door_is_open = door_open;
      rpt.alarm = overload;
      rpt.riders = riders;
      rpt.heading_up = going_up;
      return rpt;
   endfunction

   function automatic loop_pass_type make_pass(input logic tick,
                                               input logic [FLOORS-2:0] up,
                                               input logic [FLOORS-2:0] down,
                                               input logic [FLOORS-1:0] car,
                                               input logic [1:0] beam);
      loop_pass_type p;
      p.tick = tick;
      p.up_buttons = up;
      p.down_buttons = down;
      p.car_buttons = car;
      {p.outer, p.inner} = beam;
      return p;
   endfunction

   function automatic void compare_field(input string name, input logic [7:0] want,
                                         input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   // Sends one request. The sender works in bursts; at the start of each burst a
   // bursty sender may drop valid for a random gap. Valid is left high after
   // acceptance, so the next request in a burst follows without a bubble.
   task automatic send_pass(input loop_pass_type p);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         if (sender_bursty) begin
            gap = $urandom_range(0, 8);
            if (gap > 0) begin
               @(negedge clock);
               req_valid <= 1'b0;
               repeat (gap - 1) @(negedge clock);
            end
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_tick <= p.tick;
      req_up_buttons <= p.up_buttons;
      req_down_buttons <= p.down_buttons;
      req_car_buttons <= p.car_buttons;
      req_outer_blocked <= p.outer;
      req_inner_blocked <= p.inner;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_reports.push_back(step_car(p));
   endtask

   // Stops sending and waits until every owed report has been taken.
   task automatic wait_for_responses();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_DOOR_TICKS: door_ticks_cfg = data;
         CSR_MAX_RIDERS: max_riders_cfg = data[RIDERS_W-1:0];
         default: ;
      endcase
   endtask

   // Registers change only with the block idle, so a settle follows the drain.
   task automatic configure(input logic [TICKS_W-1:0] ticks, input logic [RIDERS_W-1:0] limit);
      wait_for_responses();
      repeat (FLOORS + 2) @(negedge clock);
      write_csr(CSR_DOOR_TICKS, ticks);
      write_csr(CSR_MAX_RIDERS, {{(CSR_DATA_W - RIDERS_W){1'b0}}, limit});
   endtask

   // Four passes of someone crossing the doorway: the first beam breaks, both
   // are blocked, the second alone, then clear.
   task automatic walk_through(input bit entering);
      send_pass(make_pass(1'b0, '0, '0, '0, entering ? OUTER_ONLY : INNER_ONLY));
      send_pass(make_pass(1'b0, '0, '0, '0, BOTH_BEAMS));
      send_pass(make_pass(1'b0, '0, '0, '0, entering ? INNER_ONLY : OUTER_ONLY));
      send_pass(make_pass(1'b0, '0, '0, '0, BEAMS_CLEAR));
   endtask

   // With the door closed and no calls, ticks and beams must change nothing.
   task automatic test_idle_inputs();
      send_pass(make_pass(1'b1, '0, '0, '0, BEAMS_CLEAR));
      send_pass(make_pass(1'b0, '0, '0, '0, BOTH_BEAMS));
      send_pass(make_pass(1'b1, '0, '0, '0, OUTER_ONLY));
   endtask

   // Runs the car up and down with a two-tick door. The first trip finds no
   // calls between the ends, so it plants a call at the top floor; the way back
   // does the same at floor 0. Then every button at once, which must keep the
   // down call of the floor served on the way up.
   task automatic test_door_cycle();
      send_pass(make_pass(1'b0, '0, '0, 5'b00001, BEAMS_CLEAR));
      send_pass(make_pass(1'b1, '0, '0, '0, BEAMS_CLEAR));
      send_pass(make_pass(1'b1, '0, '0, '0, BEAMS_CLEAR));
      send_pass(make_pass(1'b0, '0, '0, '0, BEAMS_CLEAR));
      send_pass(make_pass(1'b1, '0, '0, '0, BEAMS_CLEAR));
      send_pass(make_pass(1'b1, '0, '0, '0, BEAMS_CLEAR));
      send_pass(make_pass(1'b0, '1, '1, '1, BEAMS_CLEAR));
      send_pass(make_pass(1'b1, '0, '0, '0, BEAMS_CLEAR));
      send_pass(make_pass(1'b1, '0, '0, '0, BEAMS_CLEAR));
      send_pass(make_pass(1'b0, '0, '0, '0, BEAMS_CLEAR));
   endtask

   // Limit of one rider: the second entry sounds the buzzer, exits clear it, and
   // an exit with an empty car must not wrap the count.
   task automatic test_rider_counting();
      send_pass(make_pass(1'b0, '0, '0, '1, BEAMS_CLEAR));
      walk_through(1'b1);
      walk_through(1'b1);
      walk_through(1'b0);
      walk_through(1'b0);
      walk_through(1'b0);
   endtask

   // With door_ticks at zero the 8-bit timer has to wrap, so the door stays
   // open for 256 ticks.
   task automatic test_timer_wrap();
      send_pass(make_pass(1'b0, '0, '0, '1, BEAMS_CLEAR));
      repeat (258) send_pass(make_pass(1'b1, '0, '0, '0, BEAMS_CLEAR));
   endtask

   // Random traffic. Beams mostly follow whole entries or exits, so the rider
   // count and the overload logic get exercised; the rest is beam noise.
   // Buttons are usually sparse, so the car actually has to search for stops.
   task automatic run_random(input int count, input int entry_pct, input bit bursty,
                             input rsp_mode_type mode);
      loop_pass_type p;
      int         pick;
      int         hold;
      logic [1:0] step;
      sender_bursty = bursty;
      rsp_mode = mode;
      repeat (count) begin
         if (beam_script.size() == 0) begin
            pick = $urandom_range(0, 99);
            hold = $urandom_range(1, 2);
            if (pick < entry_pct) begin
               repeat (hold) beam_script.push_back(OUTER_ONLY);
               beam_script.push_back(BOTH_BEAMS);
               repeat (hold) beam_script.push_back(INNER_ONLY);
               beam_script.push_back(BEAMS_CLEAR);
            end else if (pick < entry_pct + (100 - entry_pct) * 2 / 3) begin
               repeat (hold) beam_script.push_back(INNER_ONLY);
               beam_script.push_back(BOTH_BEAMS);
               repeat (hold) beam_script.push_back(OUTER_ONLY);
               beam_script.push_back(BEAMS_CLEAR);
            end else begin
               beam_script.push_back(2'($urandom));
            end
         end
         step = beam_script.pop_front();
         p = '0;
         p.tick = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 7) == 0) begin
            p.up_buttons = (FLOORS - 1)'($urandom);
            p.down_buttons = (FLOORS - 1)'($urandom);
            p.car_buttons = FLOORS'($urandom);
         end else begin
            if ($urandom_range(0, 4) == 0) p.up_buttons[$urandom_range(0, FLOORS - 2)] = 1'b1;
            if ($urandom_range(0, 4) == 0) p.down_buttons[$urandom_range(0, FLOORS - 2)] = 1'b1;
            if ($urandom_range(0, 4) == 0) p.car_buttons[$urandom_range(0, FLOORS - 1)] = 1'b1;
         end
         {p.outer, p.inner} = step;
         send_pass(p);
         // Now and then the sender holds off until the block has caught up.
         if ($urandom_range(0, 59) == 0) wait_for_responses();
      end
   endtask

   task automatic test_random_traffic();
      configure(8'd1, 4'd4);
      run_random(45, 40, 1'b1, RSP_PATTERN);
      configure(8'd40, 4'd15);
      run_random(60, 85, 1'b1, RSP_ALWAYS);
      configure(8'd255, 4'd0);
      run_random(20, 30, 1'b0, RSP_SPARSE);
      configure(TICKS_W'($urandom_range(1, 8)), RIDERS_W'($urandom_range(0, 15)));
      run_random(45, 45, 1'b0, RSP_ALWAYS);
      configure(8'd3, 4'd8);
      run_random(40, 40, 1'b1, RSP_SPARSE);
   endtask

   // Outside the always mode the receiver stalls on a rotating 16-bit pattern,
   // redrawn now and then; the sparse mode thins it but keeps a ready bit set.
   always @(negedge clock) begin
      if (stall_age == 0) begin
         stall_pattern = 16'($urandom);
         if (rsp_mode == RSP_SPARSE) stall_pattern = stall_pattern & 16'($urandom) & 16'($urandom);
         stall_pattern[$urandom_range(0, 15)] = 1'b1;
         stall_age = 48;
      end
      stall_age--;
      rsp_ready <= (rsp_mode == RSP_ALWAYS) ? 1'b1 : stall_pattern[stall_age % 16];
   end

   // Every taken response is checked against the oldest owed report.
   always @(posedge clock) begin
      car_report_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_reports.size() == 0) begin
            $display("%0t: response with none owed, expected nothing actual floor %0d",
                     $time, rsp_floor_now);
            mismatch_count++;
         end else begin
            want = pending_reports.pop_front();
            compare_field("floor_now", 8'(want.floor_now), 8'(rsp_floor_now));
            compare_field("segments", want.segments, rsp_segments);
            compare_field("door_is_open", 8'(want.door_is_open), 8'(rsp_door_is_open));
            compare_field("alarm", 8'(want.alarm), 8'(rsp_alarm));
            compare_field("riders", 8'(want.riders), 8'(rsp_riders));
            compare_field("heading_up", 8'(want.heading_up), 8'(rsp_heading_up));
            compare_field("moved", 8'(want.moved), 8'(rsp_moved));
            compare_field("servo_steps", 8'(want.servo_steps), 8'(rsp_servo_steps));
         end
      end
   end

   // Ends the run if neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      // Reset values of the car as the block should come out of reset.
      door_ticks_cfg = DOOR_TICKS_RESET;
      max_riders_cfg = MAX_RIDERS_RESET;
      car_floor = '0;
      going_up = 1'b1;
      door_open = 1'b0;
      depart_due = 1'b0;
      door_timer = '0;
      timer_running = 1'b0;
      hall_up = '0;
      hall_down = '0;
      car_calls = '0;
      riders = '0;
      beams = '0;
      overload = 1'b0;

      repeat (11) @(negedge clock);
      reset <= 1'b0;

      test_idle_inputs();
      configure(8'd2, 4'd15);
      test_door_cycle();
      configure(8'd200, 4'd1);
      test_rider_counting();
      configure(8'd0, 4'd15);
      test_timer_wrap();
      test_random_traffic();

      // Let everything owed arrive, then watch a little longer for strays.
      wait_for_responses();
      repeat (20) @(negedge clock);
      if (mismatch_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule
